// ===== src/haptic_motor_pulse_driver_defines.svh =====
// Assertion helpers, clocked on clk and held off during arst_n.
`ifndef HAPTIC_MOTOR_PULSE_DRIVER_DEFINES_SVH
`define HAPTIC_MOTOR_PULSE_DRIVER_DEFINES_SVH

// Same-cycle implication.
`define HMPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HMPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hmpd_pkg.sv =====
package hmpd_pkg;

	localparam int PAD_COUNT_DEF = 4;
	localparam int MASK_W        = 4;
	localparam int PAD_W         = 2;
	localparam int RATE_W        = 16;
	localparam int DECAY_W       = 10;
	localparam int LIFE_W        = 15;
	localparam int ACC_W         = 18;
	localparam int STOP_W        = 2;
	localparam int PROD_W        = RATE_W + DECAY_W;

	// 100.0 in Q8.8
	localparam logic [ACC_W-1:0]   FULL_STEP  = ACC_W'(25600);
	localparam logic [RATE_W-1:0]  RATE_MAX   = '1;
	localparam logic [ACC_W-1:0]   ACC_MAX    = '1;
	localparam logic [DECAY_W-1:0] DECAY_MAX  = DECAY_W'(512);
	localparam logic [STOP_W-1:0]  STOP_TICKS = STOP_W'(3);

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_START,
		KIND_DELAY,
		KIND_STOP_ALL
	} kind_t;

endpackage

// ===== src/hmpd_cfg_if.sv =====
interface hmpd_cfg_if;
	import hmpd_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] pads_present_mask;

	modport source (output valid, output pads_present_mask, input ready);
	modport sink (input valid, input pads_present_mask, output ready);

endinterface

// ===== src/hmpd_req_if.sv =====
interface hmpd_req_if;
	import hmpd_pkg::*;

	logic               valid;
	logic               ready;
	kind_t              kind;
	logic [PAD_W-1:0]   pad;
	logic [RATE_W-1:0]  rate;
	logic [DECAY_W-1:0] decay;
	logic [LIFE_W-1:0]  life_ticks;
	logic [LIFE_W-1:0]  delay_ticks;

	modport source (
		output valid, output kind, output pad, output rate, output decay,
		output life_ticks, output delay_ticks, input ready
	);
	modport sink (
		input valid, input kind, input pad, input rate, input decay,
		input life_ticks, input delay_ticks, output ready
	);

endinterface

// ===== src/hmpd_rsp_if.sv =====
interface hmpd_rsp_if;
	import hmpd_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] motor_on_mask;
	logic [MASK_W-1:0] start_cmd_mask;
	logic [MASK_W-1:0] stop_cmd_mask;

	modport source (
		output valid, output motor_on_mask, output start_cmd_mask,
		output stop_cmd_mask, input ready
	);
	modport sink (
		input valid, input motor_on_mask, input start_cmd_mask,
		input stop_cmd_mask, output ready
	);

endinterface

// ===== src/haptic_motor_pulse_driver.sv =====
// channel | dir | beat
// --------+-----+-------------------------------------------------------
// cfg     | in  | pads_present_mask write, always ready
// req     | in  | kind, pad, rate, decay, life_ticks, delay_ticks
// rsp     | out | motor_on_mask, start_cmd_mask, stop_cmd_mask
//
// Tick beat: the pads pass one by one through the shared pad datapath (one 16x10
// multiply, saturating add, compare), min(PAD_COUNT,4) pads per beat.
// Start, delayed start and stop-all go once through RUN, then through DONE.
// req is ready only in idle; a finished result waits in DONE until the rsp
// register is free, then req opens while the result sits there.
// Reset clears all pad state at once; no clearing pass.
`include "haptic_motor_pulse_driver_defines.svh"

module haptic_motor_pulse_driver #(
	parameter int PAD_COUNT = hmpd_pkg::PAD_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hmpd_cfg_if.sink   cfg,
	hmpd_req_if.sink   req,
	hmpd_rsp_if.source rsp
);
	import hmpd_pkg::*;

	localparam int NPADS = (PAD_COUNT < MASK_W) ? PAD_COUNT : MASK_W;
	localparam int IDX_W = (NPADS > 1) ? $clog2(NPADS) : 1;
	localparam logic [IDX_W-1:0] LAST_PAD = IDX_W'(NPADS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t state_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [MASK_W-1:0] cfg_mask_q;

	// latched beat
	kind_t              kind_q;
	logic [PAD_W-1:0]   pad_q;
	logic [RATE_W-1:0]  in_rate_q;
	logic [DECAY_W-1:0] in_decay_q;
	logic [LIFE_W-1:0]  in_life_q;
	logic [LIFE_W-1:0]  in_delay_q;
	logic [MASK_W-1:0]  starts_q;
	logic [MASK_W-1:0]  stops_q;

	// per-pad state
	logic [RATE_W-1:0]  rate_q   [NPADS];
	logic [DECAY_W-1:0] decay_q  [NPADS];
	logic [ACC_W-1:0]   acc_q    [NPADS];
	logic [LIFE_W-1:0]  life_q   [NPADS];
	logic [STOP_W-1:0]  stop_q   [NPADS];
	logic [NPADS-1:0]   run_q;
	logic [RATE_W-1:0]  prate_q  [NPADS];
	logic [DECAY_W-1:0] pdecay_q [NPADS];
	logic [LIFE_W-1:0]  plife_q  [NPADS];
	logic [LIFE_W-1:0]  pdelay_q [NPADS];

	logic               rsp_valid_q;
	logic [MASK_W-1:0]  on_mask_q;
	logic [MASK_W-1:0]  start_mask_q;
	logic [MASK_W-1:0]  stop_mask_q;

	logic [IDX_W-1:0]   idx;
	logic               pad_ok;
	logic               slot_free;
	logic [DECAY_W-1:0] decay_clamped;

	// shared pad datapath
	logic               fire;
	logic [RATE_W-1:0]  e_rate;
	logic [DECAY_W-1:0] e_decay;
	logic [LIFE_W-1:0]  e_life;
	logic [STOP_W-1:0]  e_stop;
	logic [ACC_W:0]     acc_sum;
	logic [ACC_W-1:0]   acc_sat;
	logic [PROD_W-1:0]  prod;
	logic [ACC_W-1:0]   prod_sh;
	logic [RATE_W-1:0]  n_rate;
	logic [ACC_W-1:0]   n_acc;
	logic [LIFE_W-1:0]  n_life;
	logic [STOP_W-1:0]  n_stop;
	logic               n_run;
	logic [LIFE_W-1:0]  n_plife;
	logic [LIFE_W-1:0]  n_pdelay;
	logic               start_bit;
	logic               stop_bit;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.motor_on_mask  = on_mask_q;
	assign rsp.start_cmd_mask = start_mask_q;
	assign rsp.stop_cmd_mask  = stop_mask_q;

	assign slot_free     = !rsp_valid_q || rsp.ready;
	assign decay_clamped = (req.decay > DECAY_MAX) ? DECAY_MAX : req.decay;
	assign pad_ok        = (int'(pad_q) < NPADS) && cfg_mask_q[pad_q];
	assign idx           = (kind_q == KIND_TICK) ? cnt_q : IDX_W'(pad_q);

	always_comb begin
		fire    = (plife_q[idx] != '0) && (pdelay_q[idx] == '0) && (life_q[idx] == '0);
		e_rate  = fire ? prate_q[idx]  : rate_q[idx];
		e_decay = fire ? pdecay_q[idx] : decay_q[idx];
		e_life  = fire ? plife_q[idx]  : life_q[idx];
		e_stop  = fire ? STOP_TICKS    : stop_q[idx];

		acc_sum = {1'b0, acc_q[idx]} + (ACC_W + 1)'(e_rate);
		acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
		prod    = PROD_W'(e_rate) * PROD_W'(e_decay);
		prod_sh = prod[PROD_W-1:8];

		n_rate    = e_rate;
		n_acc     = acc_q[idx];
		n_life    = e_life;
		n_stop    = e_stop;
		n_run     = run_q[idx];
		n_plife   = plife_q[idx];
		n_pdelay  = pdelay_q[idx];
		start_bit = 1'b0;
		stop_bit  = 1'b0;

		if (plife_q[idx] != '0) begin
			if (pdelay_q[idx] == '0) begin
				n_plife = '0;
			end else begin
				n_pdelay = pdelay_q[idx] - 1'b1;
			end
		end

		if (e_life != '0) begin
			n_life = e_life - 1'b1;
			n_rate = (prod_sh[ACC_W-1:RATE_W] != '0) ? RATE_MAX : prod_sh[RATE_W-1:0];
			if (acc_sat >= FULL_STEP) begin
				start_bit = !run_q[idx];
				n_run     = 1'b1;
				n_acc     = acc_sat - FULL_STEP;
			end else begin
				stop_bit = run_q[idx];
				n_run    = 1'b0;
				n_acc    = acc_sat;
			end
		end else if (e_stop != '0) begin
			stop_bit = 1'b1;
			n_run    = 1'b0;
			n_stop   = e_stop - 1'b1;
			if (acc_q[idx] > FULL_STEP) begin
				n_acc = acc_q[idx] - FULL_STEP;
			end
			if (n_stop == '0) begin
				n_rate = '0;
				n_acc  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			cfg_mask_q   <= '0;
			kind_q       <= KIND_TICK;
			pad_q        <= '0;
			in_rate_q    <= '0;
			in_decay_q   <= '0;
			in_life_q    <= '0;
			in_delay_q   <= '0;
			starts_q     <= '0;
			stops_q      <= '0;
			run_q        <= '0;
			rsp_valid_q  <= 1'b0;
			on_mask_q    <= '0;
			start_mask_q <= '0;
			stop_mask_q  <= '0;
			for (int p = 0; p < NPADS; p++) begin
				rate_q[p]   <= '0;
				decay_q[p]  <= '0;
				acc_q[p]    <= '0;
				life_q[p]   <= '0;
				stop_q[p]   <= '0;
				prate_q[p]  <= '0;
				pdecay_q[p] <= '0;
				plife_q[p]  <= '0;
				pdelay_q[p] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				cfg_mask_q <= cfg.pads_present_mask;
			end
			// DONE reloads the slot itself when it drains
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						kind_q     <= req.kind;
						pad_q      <= req.pad;
						in_rate_q  <= req.rate;
						in_decay_q <= decay_clamped;
						in_life_q  <= req.life_ticks;
						in_delay_q <= req.delay_ticks;
						starts_q   <= '0;
						stops_q    <= '0;
						cnt_q      <= '0;
						state_q    <= ST_RUN;
					end
				end
				ST_RUN: begin
					unique case (kind_q)
						KIND_TICK: begin
							if (cfg_mask_q[cnt_q]) begin
								rate_q[cnt_q]   <= n_rate;
								decay_q[cnt_q]  <= e_decay;
								acc_q[cnt_q]    <= n_acc;
								life_q[cnt_q]   <= n_life;
								stop_q[cnt_q]   <= n_stop;
								run_q[cnt_q]    <= n_run;
								plife_q[cnt_q]  <= n_plife;
								pdelay_q[cnt_q] <= n_pdelay;
								starts_q[cnt_q] <= start_bit;
								stops_q[cnt_q]  <= stop_bit;
							end
						end
						KIND_START: begin
							if (pad_ok && life_q[idx] == '0) begin
								stop_q[idx]  <= STOP_TICKS;
								life_q[idx]  <= in_life_q;
								decay_q[idx] <= in_decay_q;
								rate_q[idx]  <= in_rate_q;
							end
						end
						KIND_DELAY: begin
							if (pad_ok && life_q[idx] == '0) begin
								prate_q[idx]  <= in_rate_q;
								pdecay_q[idx] <= in_decay_q;
								plife_q[idx]  <= in_life_q;
								pdelay_q[idx] <= in_delay_q;
							end
						end
						KIND_STOP_ALL: begin
							for (int p = 0; p < NPADS; p++) begin
								if (cfg_mask_q[p]) begin
									life_q[p] <= '0;
								end
							end
						end
						default: ;
					endcase
					if (kind_q != KIND_TICK || cnt_q == LAST_PAD) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						rsp_valid_q  <= 1'b1;
						on_mask_q    <= MASK_W'(run_q);
						start_mask_q <= starts_q;
						stop_mask_q  <= stops_q;
						cnt_q        <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`HMPD_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_q == ST_RUN, "beat accepted but sequencer did not start")
	`HMPD_ASSERT_NOW(a_cmd_disjoint, rsp.valid, (rsp.start_cmd_mask & rsp.stop_cmd_mask) == '0, "start and stop on the same pad")
	`HMPD_ASSERT_NOW(a_start_means_on, rsp.valid, (rsp.start_cmd_mask & ~rsp.motor_on_mask) == '0, "start issued but motor reads off")
	`HMPD_ASSERT_NOW(a_cnt_range, state_q == ST_RUN, int'(cnt_q) < NPADS, "pad counter out of range")
	`HMPD_ASSERT_NOW(a_life_keeps_stop, life_q[cnt_q] != '0, stop_q[cnt_q] == STOP_TICKS, "live pad lost its stop ticks")

endmodule
